/* hw/rtl/four_pole_resonant_filter_defines.svh */
// assertion macros used by the checker
`ifndef FOUR_POLE_RESONANT_FILTER_DEFINES_SVH
`define FOUR_POLE_RESONANT_FILTER_DEFINES_SVH

// same-cycle implication
`define FPRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fprf assertion failed");

// next-cycle implication
`define FPRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fprf assertion failed");

`endif

/* hw/rtl/fprf_pkg.sv */
package fprf_pkg;

  localparam int SmpW     = 24;
  localparam int CoefW    = 20;
  localparam int CoefFrac = 16;
  localparam int SumW     = SmpW + 1;
  localparam int ProdW    = SumW + CoefW;
  localparam int AccW     = ProdW + 1;
  localparam int NumStg   = 4;
  localparam int StgW     = $clog2(NumStg);
  localparam int NumSteps = 2 * NumStg + 1;
  localparam int StepW    = $clog2(NumSteps);

  localparam logic signed [CoefW-1:0] PassRst = CoefW'(1174);
  localparam logic signed [CoefW-1:0] PoleRst = -CoefW'(63187);
  localparam logic signed [CoefW-1:0] ResRst  = '0;

  localparam logic signed [AccW-1:0] RndHalf =
    {{(AccW-CoefFrac){1'b0}}, 1'b1, {(CoefFrac-1){1'b0}}};
  localparam logic signed [AccW-1:0] SatHi =
    {{(AccW-SmpW+1){1'b0}}, {(SmpW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo =
    {{(AccW-SmpW+1){1'b1}}, {(SmpW-1){1'b0}}};

  typedef enum logic [1:0] {
    CfgPass = 2'd0,
    CfgPole = 2'd1,
    CfgRes  = 2'd2,
    CfgHp   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StAcc,
    StFin
  } fsm_e;

  typedef logic signed [SmpW-1:0] smp_t;

  // round half up, drop the coefficient fraction
  function automatic logic signed [AccW-1:0] rnd_q16(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] b;
    b = v + RndHalf;
    rnd_q16 = b >>> CoefFrac;
  endfunction

  function automatic smp_t sat_smp(input logic signed [AccW-1:0] v);
    smp_t r;
    if (v > SatHi) begin
      r = SatHi[SmpW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[SmpW-1:0];
    end else begin
      r = v[SmpW-1:0];
    end
    sat_smp = r;
  endfunction

endpackage

/* hw/rtl/fprf_mul.sv */
module fprf_mul import fprf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SumW-1:0]  a_i,
  input  logic signed [CoefW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

/* hw/rtl/four_pole_resonant_filter.sv */
// four-pole resonant ladder filter, one shared 25x20 multiplier
// sample_out is registered, loaded in the finish state once all multiply steps for the accepted beat are done
// no new sample is taken until the last one is through nine multiply steps (StMul then StAcc), StFin and StIdle
// a full output register holds the last step until the result beat is taken
// reset: coefficients to their defaults, fed-back input and stage outputs to zero
module four_pole_resonant_filter import fprf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SmpW-1:0]  sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SmpW-1:0]  sample_out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CoefW-1:0]        cfg_data_i
);

  fsm_e state_q, state_d;

  logic signed [CoefW-1:0] pass_q, pole_q, res_q;
  logic                    hp_q;

  smp_t              x_q, fed_q, x_cur_q, x_prev_q, out_q;
  smp_t              stg_out_q [NumStg];
  logic [StepW-1:0]  step_q;
  logic [StgW-1:0]   stg_q;
  logic              out_valid_q;
  logic signed [AccW-1:0] acc_q;

  logic signed [SumW-1:0]  mul_a;
  logic signed [CoefW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic                    mul_en;
  smp_t                    fb, nv, fin_val;
  logic                    in_acc, fin_go;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == StIdle);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign mul_en       = (state_q == StMul);
  assign fin_go       = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // operand select: feedback product, then (x + x_prev) * p and y * f per stage
  always_comb begin
    if (step_q == '0) begin
      mul_a = SumW'(stg_out_q[NumStg-1]);
      mul_b = res_q;
    end else if (step_q[0]) begin
      mul_a = SumW'(x_cur_q) + SumW'(x_prev_q);
      mul_b = pass_q;
    end else begin
      mul_a = SumW'(stg_out_q[stg_q]);
      mul_b = pole_q;
    end
  end

  fprf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    fb      = sat_smp(AccW'(x_q) - rnd_q16(AccW'(prod)));
    nv      = sat_smp(rnd_q16(acc_q - AccW'(prod)));
    fin_val = hp_q ? sat_smp(AccW'(fed_q) - AccW'(stg_out_q[NumStg-1]))
                   : stg_out_q[NumStg-1];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StAcc;
      end
      StAcc: begin
        if (step_q == StepW'(NumSteps - 1)) begin
          state_d = StFin;
        end else begin
          state_d = StMul;
        end
      end
      StFin: begin
        if (fin_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= PassRst;
      pole_q <= PoleRst;
      res_q  <= ResRst;
      hp_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPass: pass_q <= cfg_data_i;
        CfgPole: pole_q <= cfg_data_i;
        CfgRes:  res_q  <= cfg_data_i;
        CfgHp:   hp_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fed_q       <= '0;
      stg_out_q   <= '{default: '0};
      step_q      <= '0;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        step_q <= '0;
        stg_q  <= '0;
      end
      if (state_q == StAcc) begin
        step_q <= step_q + 1'b1;
        if (step_q == '0) begin
          fed_q <= fb;
        end else if (!step_q[0]) begin
          stg_out_q[stg_q] <= nv;
          stg_q            <= stg_q + 1'b1;
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
    end
    if (state_q == StAcc) begin
      if (step_q == '0) begin
        x_cur_q  <= fb;
        x_prev_q <= fed_q;
      end else if (step_q[0]) begin
        acc_q <= AccW'(prod);
      end else begin
        x_cur_q  <= nv;
        x_prev_q <= stg_out_q[stg_q];
      end
    end
    if (fin_go) begin
      out_q <= fin_val;
    end
  end

endmodule

/* hw/rtl/fprf_checker.sv */
`include "four_pole_resonant_filter_defines.svh"

module fprf_checker import fprf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [SmpW-1:0]  sample_out_o
);

  // a waiting result beat holds its value
  `FPRF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sample_out_o))

  // the block is busy right after taking a sample
  `FPRF_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

  // a new result only appears at the end of a busy stretch
  `FPRF_ASSERT_NOW(a_out_after_busy, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind four_pole_resonant_filter fprf_checker u_fprf_checker (.*);

/* tb/four_pole_resonant_filter_test.sv */
module four_pole_resonant_filter_test;
  import fprf_pkg::*;

  localparam smp_t SmpMax = {1'b0, {(SmpW-1){1'b1}}};
  localparam smp_t SmpMin = {1'b1, {(SmpW-1){1'b0}}};
  localparam logic [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};
  localparam int NumPhases = 12;
  localparam int PhaseLen = 152;

  class ladder_tracker;
    longint pass_k, pole_k, res_k;
    bit hp_sel;
    longint fb_last;
    longint stg[NumStg];
    smp_t due_samples[$];
    int mismatches;

    function new();
      pass_k = longint'(PassRst);
      pole_k = longint'(PoleRst);
      res_k = longint'(ResRst);
      hp_sel = 1'b0;
      fb_last = '0;
      foreach (stg[i]) stg[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CoefW-1:0] data);
      logic signed [CoefW-1:0] sd;
      sd = data;
      case (idx)
        CfgPass: pass_k = longint'(sd);
        CfgPole: pole_k = longint'(sd);
        CfgRes: res_k = longint'(sd);
        CfgHp: hp_sel = data[0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      longint hi;
      hi = (longint'(1) <<< (SmpW - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // round half up, then drop the q16 fraction
    function longint q16(longint v);
      return (v + (longint'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
    endfunction

    function longint one_pole(longint x, longint xp, longint y);
      return clip(q16((x + xp) * pass_k - y * pole_k));
    endfunction

    function void take_sample(smp_t s);
      longint x, fb, o1, o2, o3, r;
      x = longint'(s);
      fb = clip(x - q16(res_k * stg[3]));
      o1 = stg[0];
      o2 = stg[1];
      o3 = stg[2];
      stg[0] = one_pole(fb, fb_last, o1);
      stg[1] = one_pole(stg[0], o1, o2);
      stg[2] = one_pole(stg[1], o2, o3);
      stg[3] = one_pole(stg[2], o3, stg[3]);
      fb_last = fb;
      r = hp_sel ? clip(fb - stg[3]) : stg[3];
      due_samples.push_back(smp_t'(r));
    endfunction

    function void check_sample(smp_t got);
      smp_t want;
      if (due_samples.size() == 0) begin
        $error("sample_out: unexpected beat, expected none, actual %0d", got);
        mismatches++;
        return;
      end
      want = due_samples.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  smp_t sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  smp_t sample_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;

  ladder_tracker tracker = new();
  int long_stall_req = 0;
  bit rx_steady = 1'b0;

  four_pole_resonant_filter dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_in_i(sample_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sample_out_o(sample_out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic smp_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SmpMax;
      1: return SmpMin;
      2, 3, 4: return smp_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return smp_t'($urandom);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] edge_coef();
    case ($urandom_range(0, 4))
      0: return CoefMax;
      1: return CoefMin;
      2: return '0;
      3: return '1;
      default: return CoefW'(1);
    endcase
  endfunction

  // output side: random back-pressure plus one long hold on request
  initial begin
    int rx_hold;
    int g;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) tracker.check_sample(sample_out_o);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (long_stall_req > 0) begin
        rx_hold = long_stall_req - 1;
        long_stall_req = 0;
        out_ready_i <= 1'b0;
      end else if (rx_steady) begin
        out_ready_i <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          rx_hold = g - 1;
        end
      end
    end
  end

  task automatic push_sample(smp_t s);
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_sample(s);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (tracker.due_samples.size() != 0) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back beats, lowered by the caller
  task automatic write_reg(cfg_idx_e idx, logic [CoefW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_settings(logic [CoefW-1:0] pv, logic [CoefW-1:0] fv,
                                logic [CoefW-1:0] qv, logic [CoefW-1:0] hv, bit every);
    if (every || $urandom_range(0, 3) != 0) write_reg(CfgPass, pv);
    if (every || $urandom_range(0, 3) != 0) write_reg(CfgPole, fv);
    if (every || $urandom_range(0, 3) != 0) write_reg(CfgRes, qv);
    if (every || $urandom_range(0, 3) != 0) write_reg(CfgHp, hv);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [CoefW-1:0] pv, fv, qv;
    int pi;
    case ($urandom_range(0, 3))
      0: begin
        pv = CoefW'($urandom);
        fv = CoefW'($urandom);
        qv = CoefW'($urandom);
      end
      1: begin
        pv = edge_coef();
        fv = edge_coef();
        qv = edge_coef();
      end
      default: begin
        pi = $urandom_range(0, 32768);
        pv = CoefW'(pi);
        fv = CoefW'(2 * pi - 65536);
        qv = CoefW'($urandom_range(0, 262143));
      end
    endcase
    apply_settings(pv, fv, qv, CoefW'($urandom), 1'b0);
  endtask

  task automatic run_phase(int n, bit steady, int pause_at);
    for (int k = 0; k < n; k++) begin
      push_sample(rand_sample());
      if (k == pause_at) begin
        in_valid_i <= 1'b0;
        drain();
      end else if (!steady) begin
        idle_in(pick_gap());
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    smp_t edges[8];
    edges = '{SmpMax, SmpMin, '0, '1, smp_t'(1), SmpMax, SmpMax, SmpMin};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, then both extreme corners in both modes
    foreach (edges[i]) push_sample(edges[i]);
    in_valid_i <= 1'b0;
    drain();
    apply_settings(CoefMax, CoefMin, CoefMax, '1, 1'b1);
    foreach (edges[i]) begin
      push_sample(edges[i]);
      idle_in(pick_gap());
    end
    in_valid_i <= 1'b0;
    drain();
    apply_settings(CoefMin, CoefMax, CoefMin, {{(CoefW-1){1'b1}}, 1'b0}, 1'b1);
    foreach (edges[i]) push_sample(edges[i]);
    in_valid_i <= 1'b0;
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      pick_settings();
      rx_steady = ($urandom_range(0, 4) == 0);
      if (ph == 3) begin
        rx_steady = 1'b0;
        long_stall_req = 400;
        run_phase(PhaseLen, 1'b1, -1);
      end else if (ph == 6) begin
        run_phase(PhaseLen, 1'b0, PhaseLen / 2);
      end else begin
        run_phase(PhaseLen, $urandom_range(0, 3) == 0, -1);
      end
      drain();
    end

    rx_steady = 1'b0;
    drain();
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
